// ===== src/fasrc_pkg.sv =====
// fasrc_pkg: shared types and constants of the fifo-fed linear resampler
// depends on nothing; used by fasrc_lerp_mul, fasrc_stepdiv and the top level

package fasrc_pkg;

   // request actions
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_PULL = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_TARGET_FILL    = 2'd0;
   localparam logic [1:0] CSR_MAX_CORRECTION = 2'd1;
   localparam logic [1:0] CSR_PREFILL_LEVEL  = 2'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // ppm to q32: corr * 2^32 / 10^6 == corr * 2^26 / 15625
   // floor(m * 2^26 / 15625) == (m * ceil(2^50 / 15625)) >> 24 for every 11-bit m
   localparam int          STEP_DIV_BITS    = 26;
   localparam int          STEP_RECIP_SHIFT = 24;
   localparam int          STEP_PROD_W      = 48;
   localparam logic [36:0] STEP_RECIP       = 37'd72057594038;
   localparam logic [33:0] ONE_Q32          = 34'h1_0000_0000;

   typedef struct packed {
      logic              action;
      logic signed [15:0] in_left;
      logic signed [15:0] in_right;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_left;
      logic signed [15:0] out_right;
      logic [9:0]         fill_level;
      logic signed [11:0] correction_now;
      logic               is_streaming;
      logic               underrun_flag;
      logic               dropped_flag;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [10:0] magnitude;
   } div_ctrl_type;

   typedef struct packed {
      logic                     done;
      logic [STEP_DIV_BITS-1:0] quotient;
   } div_stat_type;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_POP0, S_POP1, S_CORR, S_DIV, S_MULL, S_MULR,
      S_ADV, S_WRAP, S_WRAPW, S_RESP
   } state_type;

endpackage

// ===== src/fasrc_fifo_ram.sv =====
// fasrc_fifo_ram: frame store of the resampler fifo, one write and one read port
// depends on nothing; fasrc_pkg is not imported

module fasrc_fifo_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fasrc_lerp_mul.sv =====
// fasrc_lerp_mul: shared registered multiplier for the interpolation of both channels
// depends on fasrc_pkg

module fasrc_lerp_mul
   import fasrc_pkg::*;
(
   input  logic               clock,
   input  logic signed [16:0] delta,
   input  logic [31:0]        frac,
   output logic signed [49:0] product
);

   logic signed [49:0] product_ff;

   // sample difference times q32 phase
   always_ff @(posedge clock) begin
      product_ff <= delta * $signed({1'b0, frac});
   end

   assign product = product_ff;

endmodule

// ===== src/fasrc_stepdiv.sv =====
// fasrc_stepdiv: phase step offset |corr| * 2^26 / 15625 by reciprocal multiplication
// depends on fasrc_pkg

module fasrc_stepdiv
   import fasrc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_ctrl_type ctrl,
   output div_stat_type stat
);

   logic [STEP_PROD_W-1:0]   prod;
   logic [STEP_DIV_BITS-1:0] quot_ff, quot_in;
   logic                     done_ff, done_in;

   // constant reciprocal multiply, result registered in the cycle after start
   always_comb begin
      prod    = {37'b0, ctrl.magnitude} * {11'b0, STEP_RECIP};
      quot_in = quot_ff;
      done_in = ctrl.start;
      if (ctrl.start) begin
         quot_in = STEP_DIV_BITS'(prod >> STEP_RECIP_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quot_ff;

endmodule

// ===== src/fifo_asrc_linear_resampler.sv =====
// fifo_asrc_linear_resampler: top level, sequencer, fifo pointers and correction loop
// depends on fasrc_pkg, fasrc_fifo_ram, fasrc_lerp_mul, fasrc_stepdiv
//
// Usage: req carries either a push (action 0, one stereo frame into the fifo) or a
// pull (action 1, request one output frame). Every request gives exactly one rsp
// transfer with the samples, fill level, smoothed correction and status flags.
// Configuration is written on the csr port (index, data, write enable) by the user
// only while idle, which the block does not enforce; new values take effect at the
// next block start. A push or a silent pull goes straight to the response; a
// streaming pull takes two multiplies on the shared multiplier, then up to two fifo
// pops through the registered ram port. A pull at a block start adds the start
// check, up to two start pops and the correction update, plus the reciprocal
// multiply of the step while streaming.
// One item is in flight: req_ready is low until the rsp transfer, and the next
// req transfer comes in the cycle after it at the earliest.
// A stalled receiver holds the result in rsp_data and blocks new requests.
// Reset clears pointers, streaming state, phase and correction; the frame store
// itself is not cleared and needs no clearing pass.

module fifo_asrc_linear_resampler
   import fasrc_pkg::*;
#(
   parameter int FIFO_DEPTH   = 1024,
   parameter int BLOCK_FRAMES = 240
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int BP_W  = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
   localparam int CMP_W = (PTR_W > 10) ? PTR_W : 10;
   localparam int TW    = CMP_W + 2;

   state_type state_ff, state_in;

   logic [9:0]  target_fill_ff, prefill_ff;
   logic [10:0] max_corr_ff;

   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PTR_W-1:0] fill, blk_fill_ff, blk_fill_in;
   logic             stream_ff, stream_in;
   logic [31:0]      cur_ff, cur_in, fol_ff, fol_in;
   logic [33:0]      phase_ff, phase_in, step_ff, step_in;
   logic signed [11:0] smooth_ff, smooth_in;
   logic [BP_W-1:0]  bp_ff, bp_in;
   logic [15:0]      left_ff, left_in, right_ff, right_in;
   logic             under_ff, under_in, drop_ff, drop_in;

   logic        wr_en, rd_en;
   logic [31:0] rd_data;

   logic signed [16:0] mul_delta;
   logic signed [49:0] product;

   div_ctrl_type div_ctrl;
   div_stat_type div_stat;

   logic signed [TW-1:0] tgt_raw, lim, tgt_clamp;
   logic signed [12:0]   diff, diff_q;
   logic signed [11:0]   smooth_new;

   assign fill = wp_ff - rp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_fill_ff <= 10'd512;
         max_corr_ff    <= 11'd500;
         prefill_ff     <= 10'd512;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_FILL:    target_fill_ff <= csr_wdata[9:0];
            CSR_MAX_CORRECTION: max_corr_ff    <= csr_wdata;
            CSR_PREFILL_LEVEL:  prefill_ff     <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // correction target and smoothing
   always_comb begin
      tgt_raw = $signed(TW'(CMP_W'(blk_fill_ff))) - $signed(TW'(target_fill_ff));
      lim     = $signed(TW'(max_corr_ff));
      priority if (tgt_raw > lim) begin
         tgt_clamp = lim;
      end else if (tgt_raw < -lim) begin
         tgt_clamp = -lim;
      end else begin
         tgt_clamp = tgt_raw;
      end
      diff       = $signed(13'(tgt_clamp)) - $signed({smooth_ff[11], smooth_ff});
      diff_q     = (diff < 0) ? -((-diff) >>> 4) : (diff >>> 4);
      smooth_new = smooth_ff + 12'(diff_q);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      blk_fill_in = blk_fill_ff;
      stream_in   = stream_ff;
      cur_in      = cur_ff;
      fol_in      = fol_ff;
      phase_in    = phase_ff;
      step_in     = step_ff;
      smooth_in   = smooth_ff;
      bp_in       = bp_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      under_in    = under_ff;
      drop_in     = drop_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      div_ctrl    = '{start: 1'b0, magnitude: smooth_ff[11] ? 11'(-smooth_ff)
                                                            : smooth_ff[10:0]};
      mul_delta   = $signed({fol_ff[15], fol_ff[15:0]}) - $signed({cur_ff[15], cur_ff[15:0]});
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               left_in  = '0;
               right_in = '0;
               under_in = 1'b0;
               drop_in  = 1'b0;
               if (req_data.action == ACT_PUSH) begin
                  if (fill == {PTR_W{1'b1}}) begin
                     drop_in = 1'b1;
                  end else begin
                     wr_en = 1'b1;
                     wp_in = wp_ff + 1'b1;
                  end
                  state_in = S_RESP;
               end else begin
                  bp_in = (bp_ff == BP_W'(BLOCK_FRAMES - 1)) ? '0 : bp_ff + 1'b1;
                  priority if (bp_ff == '0) begin
                     state_in = S_START;
                  end else if (stream_ff) begin
                     state_in = S_MULL;
                  end else begin
                     state_in = S_RESP;
                  end
               end
            end
         end
         S_START: begin
            blk_fill_in = fill;
            if (!stream_ff && CMP_W'(fill) >= CMP_W'(prefill_ff) && fill != '0) begin
               rd_en    = 1'b1;
               rp_in    = rp_ff + 1'b1;
               state_in = S_POP0;
            end else begin
               state_in = S_CORR;
            end
         end
         S_POP0: begin
            cur_in = rd_data;
            if (wp_ff != rp_ff) begin
               rd_en    = 1'b1;
               rp_in    = rp_ff + 1'b1;
               state_in = S_POP1;
            end else begin
               state_in = S_CORR;
            end
         end
         S_POP1: begin
            fol_in    = rd_data;
            stream_in = 1'b1;
            phase_in  = '0;
            state_in  = S_CORR;
         end
         S_CORR: begin
            if (stream_ff) begin
               smooth_in = smooth_new;
               state_in  = S_DIV;
            end else begin
               step_in  = ONE_Q32;
               state_in = S_RESP;
            end
         end
         S_DIV: begin
            // step offset from the updated correction, ready in the next cycle
            div_ctrl.start = 1'b1;
            if (div_stat.done) begin
               div_ctrl.start = 1'b0;
               step_in = smooth_ff[11] ? ONE_Q32 - 34'(div_stat.quotient)
                                       : ONE_Q32 + 34'(div_stat.quotient);
               state_in = S_MULL;
            end
         end
         S_MULL: begin
            state_in = S_MULR;
         end
         S_MULR: begin
            mul_delta = $signed({fol_ff[31], fol_ff[31:16]})
                      - $signed({cur_ff[31], cur_ff[31:16]});
            left_in   = cur_ff[15:0] + product[47:32];
            state_in  = S_ADV;
         end
         S_ADV: begin
            right_in = cur_ff[31:16] + product[47:32];
            phase_in = phase_ff + step_ff;
            state_in = S_WRAP;
         end
         S_WRAP: begin
            if (phase_ff[33:32] != 2'b00) begin
               if (rp_ff == wp_ff) begin
                  under_in  = 1'b1;
                  stream_in = 1'b0;
                  phase_in  = '0;
                  state_in  = S_RESP;
               end else begin
                  rd_en    = 1'b1;
                  rp_in    = rp_ff + 1'b1;
                  state_in = S_WRAPW;
               end
            end else begin
               state_in = S_RESP;
            end
         end
         S_WRAPW: begin
            cur_in   = fol_ff;
            fol_in   = rd_data;
            phase_in = phase_ff - ONE_Q32;
            state_in = S_WRAP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wp_ff     <= '0;
         rp_ff     <= '0;
         stream_ff <= 1'b0;
         cur_ff    <= '0;
         fol_ff    <= '0;
         phase_ff  <= '0;
         step_ff   <= ONE_Q32;
         smooth_ff <= '0;
         bp_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         stream_ff <= stream_in;
         cur_ff    <= cur_in;
         fol_ff    <= fol_in;
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         smooth_ff <= smooth_in;
         bp_ff     <= bp_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      blk_fill_ff <= blk_fill_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      under_ff    <= under_in;
      drop_ff     <= drop_in;
   end

   assign rsp_data.out_left       = left_ff;
   assign rsp_data.out_right      = right_ff;
   assign rsp_data.fill_level     = 10'(fill);
   assign rsp_data.correction_now = smooth_ff;
   assign rsp_data.is_streaming   = stream_ff;
   assign rsp_data.underrun_flag  = under_ff;
   assign rsp_data.dropped_flag   = drop_ff;

   fasrc_fifo_ram #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data ({req_data.in_right, req_data.in_left}),
      .rd_en   (rd_en),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   fasrc_lerp_mul u_mul (
      .clock   (clock),
      .delta   (mul_delta),
      .frac    (phase_ff[31:0]),
      .product (product)
   );

   fasrc_stepdiv u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

`ifndef ASSERT_OFF
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.underrun_flag && rsp_data.dropped_flag))
      else $error("underrun and drop flagged together");

   a_underrun_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.underrun_flag) |-> !rsp_data.is_streaming)
      else $error("underrun left streaming on");

   a_phase_wrapped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |-> (phase_ff[33:32] == 2'b00))
      else $error("phase not reduced below one");

   a_silent_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_streaming && !rsp_data.underrun_flag)
         |-> (rsp_data.out_left == '0 && rsp_data.out_right == '0))
      else $error("audio output while silent");
`endif

endmodule
